>>> rtl/core/tilt_pkg.sv
package tilt_pkg;

    // Port field widths.
    localparam int SAMPLE_W = 16;
    localparam int AXIS_W   = 2;
    localparam int DEG_W    = 8;

    // Axis selector codes.
    localparam logic [AXIS_W-1:0] AXIS_Z    = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_X    = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Y    = 2'd2;
    localparam logic [AXIS_W-1:0] AXIS_NONE = 2'd3;

    // Normalization: squared magnitudes live below 2^62 and are shifted up in
    // even steps until the larger one reaches 2^60.
    localparam int NORM_W      = 62;
    localparam int NORM_STEPS  = 5;
    localparam int NORM_SHIFT0 = 32;

    // Square root: one result bit per stage.
    localparam int ROOT_W     = 31;
    localparam int ROOT_STEPS = 31;
    localparam int REM_W      = ROOT_W + 2;
    localparam int LANES      = 2;
    localparam int LANE_NUM   = 0;
    localparam int LANE_DEN   = 1;

    // CORDIC vectoring datapath, angle in Q60 radians.
    localparam int VEC_W        = 35;
    localparam int ANG_W        = 64;
    localparam int CORDIC_STEPS = 34;
    localparam logic [ANG_W-1:0] QUARTER_PI_Q60 = 64'h0C90FDAA22168C23;

    // Degree scaling: floor((ang >> 20) * 9000 / (157 * 2^40)).
    localparam int TH_LO     = 20;
    localparam int TH_W      = 41;
    localparam int SCALE_W   = 14;
    localparam int PROD_W    = TH_W + SCALE_W;
    localparam int Q_LO      = 40;
    localparam int Q_W       = PROD_W - Q_LO;
    localparam int RECIP_W   = 14;
    localparam int EST_W     = Q_W + RECIP_W;
    localparam int RECIP_SHIFT = 21;
    localparam int EST_Q_W   = EST_W - RECIP_SHIFT;
    localparam int BACK_W    = 16;
    localparam logic [SCALE_W-1:0] DEG_SCALE = 14'd9000;
    localparam logic [RECIP_W-1:0] RECIP_157 = 14'd13357;
    localparam logic [BACK_W-1:0]  DIVISOR   = 16'd157;
    localparam logic [DEG_W-1:0]   DEG_MAX   = 8'd90;

    typedef enum logic [1:0] {
        KIND_ANGLE,
        KIND_ZERO,
        KIND_UNDEF,
        KIND_FULL
    } kind_t;

    typedef struct packed {
        logic  valid;
        kind_t kind;
        logic  neg;
    } side_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] accel_x;
        logic signed [SAMPLE_W-1:0] accel_y;
        logic signed [SAMPLE_W-1:0] accel_z;
        logic [AXIS_W-1:0]          axis_select;
    } tilt_request_t;

    typedef struct packed {
        logic signed [DEG_W-1:0] tilt_degrees;
        logic                    undefined_ratio;
    } tilt_result_t;

    // Arctangent table entry in Q60: pi/4 for step zero, otherwise the
    // alternating series for atan(2^-i) with each term truncated.
    function automatic logic [ANG_W-1:0] atan_q60(input int unsigned i);
        logic [ANG_W-1:0] sum;
        logic [ANG_W-1:0] term;
        int unsigned k;
        int unsigned e;
        int unsigned d;
        sum = '0;
        if (i == 0) begin
            return QUARTER_PI_Q60;
        end
        for (k = 0; i * (2 * k + 1) <= 60; k++) begin
            d    = 2 * k + 1;
            e    = 60 - i * d;
            term = (64'd1 << e) / 64'(d);
            if (k[0]) begin
                sum = sum - term;
            end
            else begin
                sum = sum + term;
            end
        end
        return sum;
    endfunction

endpackage

>>> rtl/core/tilt_front.sv
module tilt_front
    import tilt_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  tilt_request_t       request,
    output logic [NORM_W-1:0]   num,
    output logic [NORM_W-1:0]   den,
    output side_t               side_out
);

    localparam int EXT_W = (SAMPLE_BITS > SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
    localparam int SQ_W  = 2 * SAMPLE_BITS;
    localparam int SUM_W = SQ_W + 1;

    logic [EXT_W-1:0]              x_ext;
    logic [EXT_W-1:0]              y_ext;
    logic [EXT_W-1:0]              z_ext;
    logic signed [SAMPLE_BITS-1:0] x_s;
    logic signed [SAMPLE_BITS-1:0] y_s;
    logic signed [SAMPLE_BITS-1:0] z_s;
    logic signed [SQ_W-1:0]        x_wide;
    logic signed [SQ_W-1:0]        y_wide;
    logic signed [SQ_W-1:0]        z_wide;

    logic [SQ_W-1:0]   xx_reg;
    logic [SQ_W-1:0]   yy_reg;
    logic [SQ_W-1:0]   zz_reg;
    logic [SQ_W-1:0]   xx_next;
    logic [SQ_W-1:0]   yy_next;
    logic [SQ_W-1:0]   zz_next;
    logic [AXIS_W-1:0] sel_reg;
    logic              xneg_reg;
    logic              yneg_reg;
    logic              zneg_reg;
    logic              v1_reg;

    logic [SUM_W-1:0]  num_sum;
    logic [SUM_W-1:0]  den_sum;
    logic              neg_sel;
    side_t             side_next;

    logic [NORM_W-1:0] nnum_reg [NORM_STEPS+1];
    logic [NORM_W-1:0] nden_reg [NORM_STEPS+1];
    side_t             side_reg [NORM_STEPS+1];

    // Only the low SAMPLE_BITS bits of a sample count, sign-extended from
    // the top one of them.
    always_comb
    begin
        x_ext   = EXT_W'($unsigned(request.accel_x));
        y_ext   = EXT_W'($unsigned(request.accel_y));
        z_ext   = EXT_W'($unsigned(request.accel_z));
        x_s     = signed'(x_ext[SAMPLE_BITS-1:0]);
        y_s     = signed'(y_ext[SAMPLE_BITS-1:0]);
        z_s     = signed'(z_ext[SAMPLE_BITS-1:0]);
        x_wide  = SQ_W'(x_s);
        y_wide  = SQ_W'(y_s);
        z_wide  = SQ_W'(z_s);
        xx_next = x_wide * x_wide;
        yy_next = y_wide * y_wide;
        zz_next = z_wide * z_wide;
    end

    always_ff @(posedge clk)
    begin
        xx_reg   <= xx_next;
        yy_reg   <= yy_next;
        zz_reg   <= zz_next;
        sel_reg  <= request.axis_select;
        xneg_reg <= x_s[SAMPLE_BITS-1];
        yneg_reg <= y_s[SAMPLE_BITS-1];
        zneg_reg <= z_s[SAMPLE_BITS-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
        end
    end

    always_comb
    begin
        case (sel_reg)
            AXIS_Z:
            begin
                num_sum = SUM_W'(xx_reg) + SUM_W'(yy_reg);
                den_sum = SUM_W'(zz_reg);
                neg_sel = zneg_reg;
            end
            AXIS_X:
            begin
                num_sum = SUM_W'(xx_reg);
                den_sum = SUM_W'(yy_reg) + SUM_W'(zz_reg);
                neg_sel = xneg_reg;
            end
            AXIS_Y:
            begin
                num_sum = SUM_W'(yy_reg);
                den_sum = SUM_W'(xx_reg) + SUM_W'(zz_reg);
                neg_sel = yneg_reg;
            end
            default:
            begin
                num_sum = '0;
                den_sum = '0;
                neg_sel = 1'b0;
            end
        endcase

        side_next.valid = v1_reg;
        side_next.neg   = neg_sel;
        if (sel_reg == AXIS_NONE)
        begin
            side_next.kind = KIND_ZERO;
        end
        else if ((num_sum == '0) && (den_sum == '0))
        begin
            side_next.kind = KIND_UNDEF;
        end
        else if (num_sum == '0)
        begin
            side_next.kind = KIND_ZERO;
        end
        else if (den_sum == '0)
        begin
            side_next.kind = KIND_FULL;
        end
        else
        begin
            side_next.kind = KIND_ANGLE;
        end
    end

    always_ff @(posedge clk)
    begin
        nnum_reg[0] <= NORM_W'(num_sum);
        nden_reg[0] <= NORM_W'(den_sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg[0] <= '0;
        end
        else
        begin
            side_reg[0] <= side_next;
        end
    end

    // Leading-zero search in halving even steps; the larger magnitude ends
    // with one of its top two bits set.
    for (genvar j = 0; j < NORM_STEPS; j++)
    begin : g_norm
        localparam int SH = NORM_SHIFT0 >> j;

        logic [NORM_W-1:0] lead;
        logic              can_shift;

        always_comb
        begin
            lead      = nnum_reg[j] | nden_reg[j];
            can_shift = (lead[NORM_W-1 -: SH] == '0);
        end

        always_ff @(posedge clk)
        begin
            nnum_reg[j+1] <= can_shift ? (nnum_reg[j] << SH) : nnum_reg[j];
            nden_reg[j+1] <= can_shift ? (nden_reg[j] << SH) : nden_reg[j];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                side_reg[j+1] <= '0;
            end
            else
            begin
                side_reg[j+1] <= side_reg[j];
            end
        end
    end

    assign num      = nnum_reg[NORM_STEPS];
    assign den      = nden_reg[NORM_STEPS];
    assign side_out = side_reg[NORM_STEPS];

endmodule

>>> rtl/core/tilt_isqrt.sv
module tilt_isqrt
    import tilt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [NORM_W-1:0]   num,
    input  logic [NORM_W-1:0]   den,
    input  side_t               side_in,
    output logic [ROOT_W-1:0]   root_num,
    output logic [ROOT_W-1:0]   root_den,
    output side_t               side_out
);

    localparam int LAST = ROOT_STEPS - 1;

    logic [LANES-1:0][NORM_W-1:0] rad_reg  [LAST];
    logic [LANES-1:0][REM_W-1:0]  rem_reg  [LAST];
    logic [LANES-1:0][ROOT_W-1:0] root_reg [ROOT_STEPS];
    side_t                        side_reg [ROOT_STEPS];

    // Restoring square root, both lanes side by side, one root bit a stage.
    for (genvar s = 0; s < ROOT_STEPS; s++)
    begin : g_step
        logic [LANES-1:0][NORM_W-1:0]  rad_in;
        logic [LANES-1:0][REM_W-1:0]   rem_in;
        logic [LANES-1:0][ROOT_W-1:0]  root_in;
        side_t                         side_i;
        logic [LANES-1:0][REM_W+1:0]   rem_sh;
        logic [LANES-1:0][REM_W+1:0]   trial;
        logic [LANES-1:0][REM_W+2:0]   diff;
        logic [LANES-1:0]              take;

        if (s == 0)
        begin : g_first
            always_comb
            begin
                rad_in           = '0;
                rad_in[LANE_NUM] = num;
                rad_in[LANE_DEN] = den;
                rem_in           = '0;
                root_in          = '0;
                side_i           = side_in;
            end
        end
        else
        begin : g_next
            always_comb
            begin
                rad_in  = rad_reg[s-1];
                rem_in  = rem_reg[s-1];
                root_in = root_reg[s-1];
                side_i  = side_reg[s-1];
            end
        end

        always_comb
        begin
            for (int l = 0; l < LANES; l++)
            begin
                rem_sh[l] = {rem_in[l], rad_in[l][NORM_W-1 -: 2]};
                trial[l]  = {2'b00, root_in[l], 2'b01};
                diff[l]   = {1'b0, rem_sh[l]} - {1'b0, trial[l]};
                take[l]   = !diff[l][REM_W+2];
            end
        end

        always_ff @(posedge clk)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                root_reg[s][l] <= {root_in[l][ROOT_W-2:0], take[l]};
            end
        end

        if (s < LAST)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    rem_reg[s][l] <= take[l] ? diff[l][REM_W-1:0] : rem_sh[l][REM_W-1:0];
                    rad_reg[s][l] <= rad_in[l] << 2;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                side_reg[s] <= '0;
            end
            else
            begin
                side_reg[s] <= side_i;
            end
        end
    end

    assign root_num = root_reg[LAST][LANE_NUM];
    assign root_den = root_reg[LAST][LANE_DEN];
    assign side_out = side_reg[LAST];

endmodule

>>> rtl/core/tilt_cordic.sv
module tilt_cordic
    import tilt_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [ROOT_W-1:0]       root_num,
    input  logic [ROOT_W-1:0]       root_den,
    input  side_t                   side_in,
    output logic signed [ANG_W-1:0] angle,
    output side_t                   side_out
);

    localparam int LAST = CORDIC_STEPS - 1;

    logic signed [VEC_W-1:0] vx_reg   [LAST];
    logic signed [VEC_W-1:0] vy_reg   [LAST];
    logic signed [ANG_W-1:0] ang_reg  [CORDIC_STEPS];
    side_t                   side_reg [CORDIC_STEPS];

    // Vectoring mode: drive y toward zero and sum the rotation angles.
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        localparam logic signed [ANG_W-1:0] ATAN_I = signed'(atan_q60(i));

        logic signed [VEC_W-1:0] vy_in;
        logic signed [ANG_W-1:0] ang_in;
        side_t                   side_i;
        logic                    rot_pos;

        if (i == 0)
        begin : g_first
            always_comb
            begin
                vy_in  = signed'(VEC_W'(root_num));
                ang_in = '0;
                side_i = side_in;
            end
        end
        else
        begin : g_next
            always_comb
            begin
                vy_in  = vy_reg[i-1];
                ang_in = ang_reg[i-1];
                side_i = side_reg[i-1];
            end
        end

        assign rot_pos = !vy_in[VEC_W-1];

        always_ff @(posedge clk)
        begin
            ang_reg[i] <= rot_pos ? (ang_in + ATAN_I) : (ang_in - ATAN_I);
        end

        if (i < LAST)
        begin : g_carry
            logic signed [VEC_W-1:0] vx_in;
            logic signed [VEC_W-1:0] dx;
            logic signed [VEC_W-1:0] dy;

            if (i == 0)
            begin : g_vx_first
                assign vx_in = signed'(VEC_W'(root_den));
            end
            else
            begin : g_vx_next
                assign vx_in = vx_reg[i-1];
            end

            always_comb
            begin
                dx = vy_in >>> i;
                dy = vx_in >>> i;
            end

            always_ff @(posedge clk)
            begin
                vx_reg[i] <= rot_pos ? (vx_in + dx) : (vx_in - dx);
                vy_reg[i] <= rot_pos ? (vy_in - dy) : (vy_in + dy);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                side_reg[i] <= '0;
            end
            else
            begin
                side_reg[i] <= side_i;
            end
        end
    end

    assign angle    = ang_reg[LAST];
    assign side_out = side_reg[LAST];

endmodule

>>> rtl/core/tilt_scale.sv
module tilt_scale
    import tilt_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic signed [ANG_W-1:0] angle,
    input  side_t                   side_in,
    output tilt_result_t            result,
    output logic                    done
);

    logic [TH_W-1:0]    th40;
    logic [PROD_W-1:0]  prod_next;
    logic [PROD_W-1:0]  prod_reg;
    side_t              side_a_reg;

    logic [Q_W-1:0]     q_next;
    logic [Q_W-1:0]     q_reg;
    logic [EST_W-1:0]   est_full_next;
    logic [EST_W-1:0]   est_full_reg;
    side_t              side_b_reg;

    logic [EST_Q_W-1:0] est;
    logic [BACK_W-1:0]  back;
    logic [BACK_W-1:0]  rem;
    logic               bump;
    logic [DEG_W:0]     deg_raw;
    logic [DEG_W-1:0]   deg_sat;
    logic [DEG_W-1:0]   mag;
    tilt_result_t       result_next;
    tilt_result_t       result_reg;
    logic               done_reg;

    // A negative angle counts as zero.
    always_comb
    begin
        th40      = angle[ANG_W-1] ? '0 : angle[TH_LO+TH_W-1:TH_LO];
        prod_next = PROD_W'(th40) * PROD_W'(DEG_SCALE);
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    // Divide by 157 through a reciprocal that undershoots by at most one.
    always_comb
    begin
        q_next        = prod_reg[PROD_W-1:Q_LO];
        est_full_next = EST_W'(q_next) * EST_W'(RECIP_157);
    end

    always_ff @(posedge clk)
    begin
        q_reg        <= q_next;
        est_full_reg <= est_full_next;
    end

    always_comb
    begin
        est     = est_full_reg[EST_W-1:RECIP_SHIFT];
        back    = BACK_W'(est) * DIVISOR;
        rem     = BACK_W'(q_reg) - back;
        bump    = (rem >= DIVISOR);
        deg_raw = (DEG_W+1)'(est) + (DEG_W+1)'(bump);
        deg_sat = (deg_raw > (DEG_W+1)'(DEG_MAX)) ? DEG_MAX : deg_raw[DEG_W-1:0];

        result_next.undefined_ratio = 1'b0;
        case (side_b_reg.kind)
            KIND_ANGLE:
            begin
                mag = deg_sat;
            end
            KIND_FULL:
            begin
                mag = DEG_MAX;
            end
            KIND_UNDEF:
            begin
                mag = '0;
                result_next.undefined_ratio = 1'b1;
            end
            default:
            begin
                mag = '0;
            end
        endcase
        result_next.tilt_degrees = side_b_reg.neg ? signed'(-mag) : signed'(mag);
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_a_reg <= '0;
            side_b_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            side_a_reg <= side_in;
            side_b_reg <= side_a_reg;
            done_reg   <= side_b_reg.valid;
        end
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule

>>> rtl/core/accelerometer_tilt_angle.sv
// Accelerometer tilt angle.
//
// A request carries one accelerometer sample (x, y, z) and an axis selector.
// It is taken at a rising edge where start is high and busy is low. The
// block answers every request with one result: the tilt in whole degrees
// (-90 to 90) and a flag that is set when the ratio is zero over zero.
// The result sits on the result port for exactly one cycle with done high.
//
// The datapath is a fully pipelined chain: squaring and axis selection,
// a five-stage even-shift normalizer, a 31-stage integer square root (one
// root bit per stage, numerator and denominator in parallel), a 34-stage
// CORDIC in vectoring mode, and a three-stage degree scaler. A new request
// can be taken in every cycle.
//
// The receiver cannot hold results off, so the pipeline never stalls.
// busy is high only while reset is applied and for the first cycle after
// it; after that it stays low. Reset empties the pipeline; results of
// requests in flight at reset are dropped.
module accelerometer_tilt_angle
    import tilt_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  tilt_request_t request,
    output logic          done,
    output tilt_result_t  result
);

    logic                    busy_reg;
    logic                    busy_next;
    logic                    take;

    logic [NORM_W-1:0]       norm_num;
    logic [NORM_W-1:0]       norm_den;
    side_t                   norm_side;

    logic [ROOT_W-1:0]       root_num;
    logic [ROOT_W-1:0]       root_den;
    side_t                   root_side;

    logic signed [ANG_W-1:0] angle;
    side_t                   angle_side;

    // Nothing ever backs up, so the block only refuses requests while it
    // comes out of reset.
    assign busy_next = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    assign busy = busy_reg;
    assign take = start & ~busy_reg;

    // Squares, axis selection, special cases and normalization.
    tilt_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (take),
        .request  (request),
        .num      (norm_num),
        .den      (norm_den),
        .side_out (norm_side)
    );

    // Square roots of the normalized squared magnitudes.
    tilt_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .num      (norm_num),
        .den      (norm_den),
        .side_in  (norm_side),
        .root_num (root_num),
        .root_den (root_den),
        .side_out (root_side)
    );

    // Arctangent of numerator over denominator in Q60 radians.
    tilt_cordic u_cordic (
        .clk      (clk),
        .rst_n    (rst_n),
        .root_num (root_num),
        .root_den (root_den),
        .side_in  (root_side),
        .angle    (angle),
        .side_out (angle_side)
    );

    // Radians to whole degrees, sign and special cases, output register.
    tilt_scale u_scale (
        .clk     (clk),
        .rst_n   (rst_n),
        .angle   (angle),
        .side_in (angle_side),
        .result  (result),
        .done    (done)
    );

endmodule

>>> test/tb_accelerometer_tilt_angle.sv
`timescale 1ns / 1ps

module tb_accelerometer_tilt_angle;
    import tilt_pkg::*;

    // The block is built with full-width samples, so no upper bits are dropped.
    localparam int SAMPLE_BITS = 16;

    // The tail wait is longer than the time the pipeline takes to answer a
    // request that it has taken.
    localparam int DRAIN_CYCLES = 90;

    // The watchdog fires when this many cycles pass with neither a request
    // taken nor a result seen. The slowest legal stretch is the pipeline
    // latency plus a long idle run of the sender.
    localparam int WATCHDOG_LIMIT = 2000;

    // Random requests per idle profile. There are three profiles, so the
    // random part is about 400 requests in total.
    localparam int RANDOM_PER_PHASE = 134;

    // One row of the directed table. When has_result is set, the expected
    // result was written in by hand. Otherwise the predictor supplies it.
    typedef struct {
        tilt_request_t rq;
        bit            has_result;
        tilt_result_t  res;
    } tilt_row_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          start = 1'b0;
    logic          busy;
    tilt_request_t request = '0;
    logic          done;
    tilt_result_t  result;

    // Expected results, oldest first, one per request that was taken.
    tilt_result_t  pending_tilts[$];
    tilt_row_t     directed_rows[$];

    // The arctangent of 2^-i in Q60 radians for each CORDIC step.
    logic [63:0]   arctan_q60[CORDIC_STEPS];

    // These are set by the driver on the falling edge together with the
    // request. The monitor reads them on the next rising edge.
    bit            drive_typed = 1'b0;
    tilt_result_t  drive_expect = '0;

    int            error_count = 0;
    int            stall_cycles = 0;
    int            n_requests = 0;
    int            n_directed = 0;
    int            n_undefined = 0;
    int            n_saturated = 0;
    int            n_axis[4] = '{0, 0, 0, 0};

    accelerometer_tilt_angle #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .request(request),
        .done(done),
        .result(result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The table follows the truncated alternating series of atan(2^-i).
    // Step zero is the quarter-pi constant.
    initial
    begin
        longint unsigned acc;
        longint unsigned term;
        int n;
        int k;
        arctan_q60[0] = QUARTER_PI_Q60;
        for (n = 1; n < CORDIC_STEPS; n++)
        begin
            acc = 0;
            for (k = 0; n * (2 * k + 1) <= 60; k++)
            begin
                term = (64'd1 << (60 - n * (2 * k + 1))) / 64'(2 * k + 1);
                acc  = (k % 2 == 1) ? acc - term : acc + term;
            end
            arctan_q60[n] = acc;
        end
    end

    // Sign-extend a sample from bit SAMPLE_BITS-1. Any bits above are dropped.
    function automatic longint signed widen_sample(input logic [SAMPLE_W-1:0] v);
        longint signed t;
        t = longint'(v);
        t = t <<< (64 - SAMPLE_BITS);
        return t >>> (64 - SAMPLE_BITS);
    endfunction

    // Truncating integer square root. The argument is always below 2^62, so
    // the root fits in 31 bits and no trial square overflows.
    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned cand;
        int b;
        r = 0;
        for (b = 30; b >= 0; b--)
        begin
            cand = r | (64'd1 << b);
            if (cand * cand <= v)
            begin
                r = cand;
            end
        end
        return r;
    endfunction

    // Predict the tilt for one request. The steps are: exact squared
    // magnitudes, an even left shift until the larger one reaches 2^60,
    // integer roots, a 34-step vectoring CORDIC in Q60, and the scaling to
    // degrees by 9000/157 with saturation at 90. The sign is applied last.
    function automatic tilt_result_t predict_tilt(input tilt_request_t rq);
        tilt_result_t    res;
        longint signed   sx;
        longint signed   sy;
        longint signed   sz;
        longint unsigned xx;
        longint unsigned yy;
        longint unsigned zz;
        longint unsigned num2;
        longint unsigned den2;
        longint unsigned big;
        longint unsigned th;
        longint unsigned deg;
        longint signed   vx;
        longint signed   vy;
        longint signed   dx;
        longint signed   dy;
        longint signed   ang;
        logic            neg;
        int              i;
        res = '0;
        sx  = widen_sample(rq.accel_x);
        sy  = widen_sample(rq.accel_y);
        sz  = widen_sample(rq.accel_z);
        xx  = sx * sx;
        yy  = sy * sy;
        zz  = sz * sz;
        case (rq.axis_select)
            AXIS_Z:
            begin
                num2 = xx + yy;
                den2 = zz;
                neg  = sz < 0;
            end
            AXIS_X:
            begin
                num2 = xx;
                den2 = yy + zz;
                neg  = sx < 0;
            end
            AXIS_Y:
            begin
                num2 = yy;
                den2 = xx + zz;
                neg  = sy < 0;
            end
            default:
            begin
                return res;
            end
        endcase
        // A zero numerator gives an angle of zero. When the denominator is
        // zero as well, the ratio is undefined and the flag is set.
        if (num2 == 0)
        begin
            res.undefined_ratio = (den2 == 0);
            return res;
        end
        if (den2 == 0)
        begin
            deg = 90;
        end
        else
        begin
            big = (num2 > den2) ? num2 : den2;
            while (big < (64'd1 << 60))
            begin
                big  = big << 2;
                num2 = num2 << 2;
                den2 = den2 << 2;
            end
            vx  = longint'(floor_sqrt(den2));
            vy  = longint'(floor_sqrt(num2));
            ang = 0;
            for (i = 0; i < CORDIC_STEPS; i++)
            begin
                dx = vy >>> i;
                dy = vx >>> i;
                if (vy >= 0)
                begin
                    vx  = vx + dx;
                    vy  = vy - dy;
                    ang = ang + longint'(arctan_q60[i]);
                end
                else
                begin
                    vx  = vx - dx;
                    vy  = vy + dy;
                    ang = ang - longint'(arctan_q60[i]);
                end
            end
            if (ang < 0)
            begin
                ang = 0;
            end
            th  = ang;
            th  = th >> 20;
            deg = (th * 64'd9000) / (64'd157 << 40);
            if (deg > 90)
            begin
                deg = 90;
            end
        end
        res.tilt_degrees = DEG_W'(neg ? -deg : deg);
        return res;
    endfunction

    // Add one row to the directed table. Samples are given as integers and
    // truncated to the port width.
    function automatic void add_row(input int x, input int y, input int z,
                                    input logic [AXIS_W-1:0] axis,
                                    input bit has_result,
                                    input int deg, input bit undef);
        tilt_row_t row;
        row.rq.accel_x                = SAMPLE_W'(x);
        row.rq.accel_y                = SAMPLE_W'(y);
        row.rq.accel_z                = SAMPLE_W'(z);
        row.rq.axis_select            = axis;
        row.has_result                = has_result;
        row.res.tilt_degrees          = DEG_W'(deg);
        row.res.undefined_ratio       = undef;
        directed_rows.push_back(row);
    endfunction

    // Random samples are mostly uniform. About a quarter of them are near
    // zero or exactly zero, so that the zero cases come up often. Some are
    // the extremes of the range.
    function automatic logic [SAMPLE_W-1:0] random_sample();
        logic [SAMPLE_W-1:0] v;
        case ($urandom_range(0, 7))
            0: v = '0;
            1: v = SAMPLE_W'(int'($urandom_range(0, 16)) - 8);
            2:
            begin
                case ($urandom_range(0, 3))
                    0: v = 16'h8000;
                    1: v = 16'h7FFF;
                    2: v = 16'hFFFF;
                    default: v = 16'h0001;
                endcase
            end
            default: v = SAMPLE_W'($urandom);
        endcase
        return v;
    endfunction

    // Offer one request, starting on a falling edge. First idle for a random
    // number of cycles, then hold start high until the block takes the
    // request. The task returns on the falling edge after the request was
    // taken.
    task automatic send_tilt(input tilt_request_t rq, input bit has_result,
                             input tilt_result_t want, input int idle_pct);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        request      <= rq;
        start        <= 1'b1;
        drive_typed  = has_result;
        drive_expect = want;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // Stop sending and wait until every expected result has come back. The
    // first wait always advances time, so start is never lowered and raised
    // again within one time step.
    task automatic drain_pipeline();
        start <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (pending_tilts.size() != 0);
    endtask

    // The monitor runs on every rising edge. It checks the result that was
    // on the port during the cycle that just ended, and it records the
    // expectation for a request that is taken at this edge. Result first,
    // request second, in the same block, so that the order never depends on
    // the scheduler. The pipeline latency means that a request can never be
    // answered at the edge that takes it.
    always @(posedge clk)
    begin
        tilt_result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_tilts.size() == 0)
                begin
                    $display("%0t: result with no request waiting: tilt_degrees %0d "
                             , $time, result.tilt_degrees,
                             "undefined_ratio %0b", result.undefined_ratio);
                    error_count++;
                end
                else
                begin
                    want = pending_tilts.pop_front();
                    if (result.tilt_degrees !== want.tilt_degrees)
                    begin
                        $display("%0t: tilt_degrees expected %0d, actual %0d",
                                 $time, want.tilt_degrees, result.tilt_degrees);
                        error_count++;
                    end
                    if (result.undefined_ratio !== want.undefined_ratio)
                    begin
                        $display("%0t: undefined_ratio expected %0b, actual %0b",
                                 $time, want.undefined_ratio, result.undefined_ratio);
                        error_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                want = drive_typed ? drive_expect : predict_tilt(request);
                pending_tilts.push_back(want);
                n_requests++;
                n_axis[request.axis_select]++;
                if (want.undefined_ratio)
                begin
                    n_undefined++;
                end
                if (want.tilt_degrees == 8'sd90 || want.tilt_degrees == -8'sd90)
                begin
                    n_saturated++;
                end
            end
            if (done || (start && !busy))
            begin
                stall_cycles = 0;
            end
            else
            begin
                stall_cycles++;
            end
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog expired with %0d results outstanding",
                         $time, pending_tilts.size());
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        tilt_request_t rq;
        tilt_result_t  none;
        int            idle_profile[3];
        int            phase;

        none            = '0;
        idle_profile[0] = 6;
        idle_profile[1] = 67;
        idle_profile[2] = 0;

        // Directed table. The expected result is written in for these cases:
        // selector three, zero over zero, a zero numerator, and a zero
        // denominator, which saturates to 90 degrees with the axis sign. The
        // remaining rows use full-scale and unit samples, and the predictor
        // supplies their results.
        add_row(0, 0, 0, AXIS_NONE, 1'b1, 0, 1'b0);
        add_row(32767, -32768, 32767, AXIS_NONE, 1'b1, 0, 1'b0);
        add_row(0, 0, 0, AXIS_Z, 1'b1, 0, 1'b1);
        add_row(0, 0, 0, AXIS_X, 1'b1, 0, 1'b1);
        add_row(0, 0, 0, AXIS_Y, 1'b1, 0, 1'b1);
        add_row(0, 0, -32768, AXIS_Z, 1'b1, 0, 1'b0);
        add_row(0, 32767, -32768, AXIS_X, 1'b1, 0, 1'b0);
        add_row(-32768, 0, 32767, AXIS_Y, 1'b1, 0, 1'b0);
        add_row(32767, 0, 0, AXIS_Z, 1'b1, 90, 1'b0);
        add_row(-32768, -32768, 0, AXIS_Z, 1'b1, 90, 1'b0);
        add_row(-32768, 0, 0, AXIS_X, 1'b1, -90, 1'b0);
        add_row(32767, 0, 0, AXIS_X, 1'b1, 90, 1'b0);
        add_row(0, -32768, 0, AXIS_Y, 1'b1, -90, 1'b0);
        add_row(0, 32767, 0, AXIS_Y, 1'b1, 90, 1'b0);
        add_row(1, 0, -1, AXIS_Z, 1'b0, 0, 1'b0);
        add_row(32767, 32767, -32768, AXIS_Z, 1'b0, 0, 1'b0);
        add_row(-1, -1, -1, AXIS_X, 1'b0, 0, 1'b0);
        add_row(-32768, -32768, -32768, AXIS_Y, 1'b0, 0, 1'b0);
        add_row(1, 32767, 32767, AXIS_X, 1'b0, 0, 1'b0);
        add_row(32767, 1, 0, AXIS_Y, 1'b0, 0, 1'b0);
        add_row(-32768, 32767, 1, AXIS_Z, 1'b0, 0, 1'b0);
        add_row(-32768, 32767, -1, AXIS_Z, 1'b0, 0, 1'b0);
        add_row(-1, 32767, 1, AXIS_Y, 1'b0, 0, 1'b0);

        // Reset is applied once, at the start of the run. It is released
        // on a falling edge, away from the sampling edge.
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // The directed rows are sent back to back. The block may still hold
        // busy high for a cycle after reset, and the driver waits that out.
        foreach (directed_rows[r])
        begin
            send_tilt(directed_rows[r].rq, directed_rows[r].has_result,
                      directed_rows[r].res, 0);
        end
        n_directed = directed_rows.size();

        // Random requests come in three idle profiles for the sender. Before
        // each profile the sender stops until the pipeline is empty, so that
        // a full drain and restart is also exercised.
        for (phase = 0; phase < 3; phase++)
        begin
            drain_pipeline();
            repeat (RANDOM_PER_PHASE)
            begin
                rq.accel_x     = random_sample();
                rq.accel_y     = random_sample();
                rq.accel_z     = random_sample();
                rq.axis_select = AXIS_W'($urandom_range(0, 3));
                send_tilt(rq, 1'b0, none, idle_profile[phase]);
            end
        end

        // Wait for the last results, then a little longer, so that any stray
        // extra result is caught.
        drain_pipeline();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Covered %0d requests (%0d from the directed table);",
                 n_requests, n_directed);
        $display("  z %0d, x %0d, y %0d, none %0d; undefined ratios %0d, saturated %0d.",
                 n_axis[0], n_axis[1], n_axis[2], n_axis[3], n_undefined, n_saturated);
        if (error_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/tilt_pkg.sv
rtl/core/tilt_front.sv
rtl/core/tilt_isqrt.sv
rtl/core/tilt_cordic.sv
rtl/core/tilt_scale.sv
rtl/core/accelerometer_tilt_angle.sv
test/tb_accelerometer_tilt_angle.sv
